@@ design/tccf_pkg.sv @@
`timescale 1ns / 1ps

package tccf_pkg;

    // datapath widths
    localparam int DW = 52;   // CORDIC x/y and magnetometer sums
    localparam int ZW = 34;   // CORDIC angle, Q23 degrees
    localparam int MW = 33;   // multiplier operand
    localparam int PW = 66;   // multiplier product
    localparam int TAB_LEN = 24;

    localparam logic signed [ZW-1:0] Z_HALF_TURN = 34'sd1509949440;  // 180 deg in Q23
    localparam logic signed [ZW-1:0] Z_RND       = 34'sd32768;
    localparam logic signed [ZW-1:0] Z_YAW_LIM   = 34'sd23040;
    localparam logic signed [31:0]   CORDIC_GAIN = 32'sd652032874;   // Q30
    localparam logic signed [31:0]   ANG_LIM     = 32'sd46080;
    localparam logic signed [17:0]   YAW_LIM     = 18'sd23040;
    localparam logic signed [17:0]   TURN        = 18'sd46080;
    localparam logic signed [17:0]   QTR_LIM     = 18'sd11520;
    localparam logic [16:0]          KEEP_ONE    = 17'd65536;
    localparam logic [16:0]          KEEP_RESET  = 17'd62259;
    // floor(2^38 / 125), result low by at most one
    localparam logic signed [MW-1:0] RECIP_125   = 33'sd2199023255;
    localparam int                   RECIP_SHIFT = 38;

    localparam logic                 REG_KEEP_WEIGHT = 1'b0;

    typedef struct packed {
        logic        [15:0] elapsed_ms;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] mag_z;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_x;
        logic signed [15:0] acc_z;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_x;
    } sample_t;

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } cordic_mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PV_GO,
        ST_PV_RUN,
        ST_RV_GO,
        ST_RV_RUN,
        ST_GM1,
        ST_GM2,
        ST_GM3,
        ST_GM4,
        ST_BM1,
        ST_BM2,
        ST_BM3,
        ST_SC_GO,
        ST_SC_RUN,
        ST_MM,
        ST_YV_GO,
        ST_YV_RUN,
        ST_OUT
    } seq_state_t;

    // atan(2^-i) in degrees, Q23
    function automatic logic signed [ZW-1:0] atan_q23(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_q23 = 34'sd377487360;
            5'd1:    atan_q23 = 34'sd222843801;
            5'd2:    atan_q23 = 34'sd117744544;
            5'd3:    atan_q23 = 34'sd59768969;
            5'd4:    atan_q23 = 34'sd30000467;
            5'd5:    atan_q23 = 34'sd15014858;
            5'd6:    atan_q23 = 34'sd7509261;
            5'd7:    atan_q23 = 34'sd3754860;
            5'd8:    atan_q23 = 34'sd1877459;
            5'd9:    atan_q23 = 34'sd938733;
            5'd10:   atan_q23 = 34'sd469367;
            5'd11:   atan_q23 = 34'sd234683;
            5'd12:   atan_q23 = 34'sd117342;
            5'd13:   atan_q23 = 34'sd58671;
            5'd14:   atan_q23 = 34'sd29335;
            5'd15:   atan_q23 = 34'sd14668;
            5'd16:   atan_q23 = 34'sd7334;
            5'd17:   atan_q23 = 34'sd3667;
            5'd18:   atan_q23 = 34'sd1833;
            5'd19:   atan_q23 = 34'sd917;
            5'd20:   atan_q23 = 34'sd458;
            5'd21:   atan_q23 = 34'sd229;
            5'd22:   atan_q23 = 34'sd115;
            5'd23:   atan_q23 = 34'sd57;
            default: atan_q23 = '0;
        endcase
    endfunction

    // Q23 degrees to 1/128 degree, rounded, clamped to the atan2 range
    function automatic logic signed [15:0] z_to_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] r;
        r = (z + Z_RND) >>> 16;
        if (r > Z_YAW_LIM) begin
            r = Z_YAW_LIM;
        end else if (r < -Z_YAW_LIM) begin
            r = -Z_YAW_LIM;
        end
        z_to_angle = r[15:0];
    endfunction

endpackage

@@ design/tccf_front.sv @@
`timescale 1ns / 1ps

module tccf_front import tccf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  sample_t     s_sample,
    output logic        q_valid,
    output sample_t     q_sample,
    input  logic        q_pop
);

    // two-word queue between intake and sequencer
    sample_t    mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_sample = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

@@ design/tccf_cordic.sv @@
`timescale 1ns / 1ps

module tccf_cordic import tccf_pkg::*; #(
    parameter int ITER = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 go,
    input  cordic_mode_t         mode,
    input  logic signed [DW-1:0] x0,
    input  logic signed [DW-1:0] y0,
    input  logic signed [ZW-1:0] z0,
    output logic signed [DW-1:0] x,
    output logic signed [DW-1:0] y,
    output logic signed [ZW-1:0] z,
    output logic                 done
);

    localparam int         STEPS = (ITER > TAB_LEN) ? TAB_LEN : ITER;
    localparam logic [4:0] LAST  = 5'(STEPS - 1);

    logic [4:0]           i_reg;
    logic                 busy_reg, done_reg;
    cordic_mode_t         mode_reg;
    logic signed [DW-1:0] x_reg, y_reg, dx, dy;
    logic signed [ZW-1:0] z_reg, a;
    logic                 cw;

    always_comb begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        a  = atan_q23(i_reg);
        cw = (mode_reg == CM_VECTOR) ? (y_reg > 0) : (z_reg < 0);
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            mode_reg <= mode;
        end else if (busy_reg) begin
            if (cw) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + a;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (go) begin
            i_reg    <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (i_reg == LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

endmodule

@@ design/tccf_back.sv @@
`timescale 1ns / 1ps

module tccf_back import tccf_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  sample_t     q_sample,
    output logic        q_pop,
    input  logic [16:0] keep_eff,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata
);

    function automatic logic signed [MW-1:0] sx16(input logic signed [15:0] v);
        sx16 = {{(MW-16){v[15]}}, v};
    endfunction

    function automatic logic signed [MW-1:0] sx32(input logic signed [31:0] v);
        sx32 = {v[31], v};
    endfunction

    function automatic logic signed [DW-1:0] acc_scaled(input logic signed [15:0] v);
        acc_scaled = {{(DW-40){v[15]}}, v, 24'd0};
    endfunction

    function automatic logic signed [31:0] q30_round(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] r;
        r = (p + (PW'(1) <<< 29)) >>> 30;
        q30_round = r[31:0];
    endfunction

    seq_state_t           st_reg, st_next;
    logic                 sel_reg;
    logic [2:0]           mm_reg;
    sample_t              smp_reg;
    logic signed [16:0]   theta_m_reg, phi_m_reg, theta_reg, phi_reg;
    logic signed [16:0]   pitch_state_reg, roll_state_reg;
    logic [31:0]          u_reg;
    logic                 neg_reg, flip_reg;
    logic signed [26:0]   adv_reg;
    logic signed [47:0]   acc_reg;
    logic signed [31:0]   ct_reg, st_q_reg, cp_reg, sp_reg, t1_reg, t2_reg;
    logic signed [DW-1:0] xm_reg, ym_reg;
    logic signed [15:0]   yaw_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 out_valid_reg;
    logic [55:0]          out_data_reg;

    logic signed [MW-1:0] mul_a, mul_b;

    // CORDIC load
    logic                 c_go, v_zero;
    cordic_mode_t         c_mode;
    logic signed [DW-1:0] vx, vy, c_x0, c_y0, c_x, c_y;
    logic signed [ZW-1:0] c_z0, c_z;
    logic                 c_done;
    logic signed [17:0]   ang, ang_w, ang_r;
    logic                 rot_neg;

    // gyro step and blend helpers
    logic signed [32:0]   n_val;
    logic [32:0]          n_abs;
    logic [25:0]          q0, q1;
    logic [33:0]          rem;
    logic signed [26:0]   step;
    logic signed [47:0]   bl_sum;
    logic signed [31:0]   bl_sh, bl_sat;
    logic signed [15:0]   c_ang;
    logic                 out_load;

    tccf_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (c_go),
        .mode    (c_mode),
        .x0      (c_x0),
        .y0      (c_y0),
        .z0      (c_z0),
        .x       (c_x),
        .y       (c_y),
        .z       (c_z),
        .done    (c_done)
    );

    always_comb begin
        // vectoring operands
        case (st_reg)
            ST_PV_GO: begin
                vx = acc_scaled(smp_reg.acc_z);
                vy = acc_scaled(smp_reg.acc_x);
            end
            ST_RV_GO: begin
                vx = acc_scaled(smp_reg.acc_z);
                vy = acc_scaled(smp_reg.acc_y);
            end
            default: begin
                vx = xm_reg;
                vy = ym_reg;
            end
        endcase
        v_zero = (vx == '0) && (vy == '0);

        // rotation angle folded into +-90 deg
        ang = sel_reg ? 18'(phi_reg) : 18'(theta_reg);
        if (ang > YAW_LIM) begin
            ang_w = ang - TURN;
        end else if (ang <= -YAW_LIM) begin
            ang_w = ang + TURN;
        end else begin
            ang_w = ang;
        end
        rot_neg = 1'b1;
        if (ang_w > QTR_LIM) begin
            ang_r = ang_w - YAW_LIM;
        end else if (ang_w < -QTR_LIM) begin
            ang_r = ang_w + YAW_LIM;
        end else begin
            ang_r   = ang_w;
            rot_neg = 1'b0;
        end

        if (st_reg == ST_SC_GO) begin
            c_mode = CM_ROTATE;
            c_x0   = DW'(CORDIC_GAIN);
            c_y0   = '0;
            c_z0   = ZW'(ang_r) <<< 16;
            c_go   = 1'b1;
        end else begin
            c_mode = CM_VECTOR;
            if (vx < 0) begin
                c_x0 = -vx;
                c_y0 = -vy;
                c_z0 = (vy < 0) ? -Z_HALF_TURN : Z_HALF_TURN;
            end else begin
                c_x0 = vx;
                c_y0 = vy;
                c_z0 = '0;
            end
            c_go = ((st_reg == ST_PV_GO) || (st_reg == ST_RV_GO) || (st_reg == ST_YV_GO))
                   && !v_zero;
        end
        c_ang = z_to_angle(c_z);

        // divide by 125 with one correction step
        n_val = prod_reg[32:0];
        n_abs = (n_val < 0) ? 33'(-n_val) : 33'(n_val);
        q0    = prod_reg[RECIP_SHIFT+25:RECIP_SHIFT];
        rem   = 34'(u_reg) - 34'(q0) * 34'd125;
        q1    = (rem >= 34'd125) ? q0 + 26'd1 : q0;
        step  = neg_reg ? -27'(q1) : 27'(q1);

        // blend finish
        bl_sum = acc_reg + prod_reg[47:0] + 48'sd32768;
        bl_sh  = 32'(bl_sum >>> 16);
        if (bl_sh > ANG_LIM) begin
            bl_sat = ANG_LIM;
        end else if (bl_sh < -ANG_LIM) begin
            bl_sat = -ANG_LIM;
        end else begin
            bl_sat = bl_sh;
        end

        // shared multiplier operands
        mul_a = '0;
        mul_b = '0;
        case (st_reg)
            ST_GM1: begin
                mul_a = sx16(sel_reg ? smp_reg.gyro_x : smp_reg.gyro_y);
                mul_b = {17'd0, smp_reg.elapsed_ms};
            end
            ST_GM3: begin
                mul_a = {1'b0, u_reg};
                mul_b = RECIP_125;
            end
            ST_BM1: begin
                mul_a = MW'(adv_reg);
                mul_b = {16'd0, keep_eff};
            end
            ST_BM2: begin
                mul_a = MW'(sel_reg ? phi_m_reg : theta_m_reg);
                mul_b = {16'd0, KEEP_ONE - keep_eff};
            end
            ST_MM: begin
                case (mm_reg)
                    3'd0: begin mul_a = sx32(sp_reg); mul_b = sx32(st_q_reg); end
                    3'd1: begin mul_a = sx32(cp_reg); mul_b = sx32(st_q_reg); end
                    3'd2: begin mul_a = sx16(smp_reg.mag_x); mul_b = sx32(ct_reg); end
                    3'd3: begin mul_a = sx16(smp_reg.mag_y); mul_b = sx32(t1_reg); end
                    3'd4: begin mul_a = sx16(smp_reg.mag_z); mul_b = sx32(t2_reg); end
                    3'd5: begin mul_a = sx16(smp_reg.mag_y); mul_b = sx32(cp_reg); end
                    3'd6: begin mul_a = sx16(smp_reg.mag_z); mul_b = sx32(sp_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        st_next  = st_reg;
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop   = 1'b1;
                    st_next = ST_PV_GO;
                end
            end
            ST_PV_GO:  st_next = v_zero ? ST_RV_GO : ST_PV_RUN;
            ST_PV_RUN: st_next = c_done ? ST_RV_GO : ST_PV_RUN;
            ST_RV_GO:  st_next = v_zero ? ST_GM1 : ST_RV_RUN;
            ST_RV_RUN: st_next = c_done ? ST_GM1 : ST_RV_RUN;
            ST_GM1:    st_next = ST_GM2;
            ST_GM2:    st_next = ST_GM3;
            ST_GM3:    st_next = ST_GM4;
            ST_GM4:    st_next = ST_BM1;
            ST_BM1:    st_next = ST_BM2;
            ST_BM2:    st_next = ST_BM3;
            ST_BM3:    st_next = sel_reg ? ST_SC_GO : ST_GM1;
            ST_SC_GO:  st_next = ST_SC_RUN;
            ST_SC_RUN: begin
                if (c_done) begin
                    st_next = sel_reg ? ST_MM : ST_SC_GO;
                end
            end
            ST_MM:     st_next = (mm_reg == 3'd7) ? ST_YV_GO : ST_MM;
            ST_YV_GO:  st_next = v_zero ? ST_OUT : ST_YV_RUN;
            ST_YV_RUN: st_next = c_done ? ST_OUT : ST_YV_RUN;
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load = 1'b1;
                    st_next  = ST_IDLE;
                end
            end
            default:   st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg          <= ST_IDLE;
            sel_reg         <= 1'b0;
            mm_reg          <= '0;
            pitch_state_reg <= '0;
            roll_state_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_BM3: begin
                    sel_reg <= ~sel_reg;
                    if (sel_reg) begin
                        roll_state_reg <= 17'(bl_sat);
                    end else begin
                        pitch_state_reg <= 17'(bl_sat);
                    end
                end
                ST_SC_RUN: begin
                    if (c_done) begin
                        sel_reg <= ~sel_reg;
                        mm_reg  <= '0;
                    end
                end
                ST_MM:   mm_reg <= mm_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (q_pop) begin
            smp_reg <= q_sample;
        end
        case (st_reg)
            ST_PV_GO:  if (v_zero) theta_m_reg <= '0;
            ST_PV_RUN: if (c_done) theta_m_reg <= -17'(c_ang);
            ST_RV_GO:  if (v_zero) phi_m_reg <= '0;
            ST_RV_RUN: if (c_done) phi_m_reg <= -17'(c_ang);
            ST_GM2: begin
                neg_reg <= (n_val < 0);
                u_reg   <= n_abs[31:0] + 32'd62;
            end
            ST_GM4: begin
                adv_reg <= sel_reg ? 27'(roll_state_reg) - step
                                   : 27'(pitch_state_reg) + step;
            end
            ST_BM2: acc_reg <= prod_reg[47:0];
            ST_BM3: begin
                if (sel_reg) begin
                    phi_reg <= 17'(bl_sat);
                end else begin
                    theta_reg <= 17'(bl_sat);
                end
            end
            ST_SC_GO: flip_reg <= rot_neg;
            ST_SC_RUN: begin
                if (c_done) begin
                    if (sel_reg) begin
                        cp_reg <= flip_reg ? -c_x[31:0] : c_x[31:0];
                        sp_reg <= flip_reg ? -c_y[31:0] : c_y[31:0];
                    end else begin
                        ct_reg   <= flip_reg ? -c_x[31:0] : c_x[31:0];
                        st_q_reg <= flip_reg ? -c_y[31:0] : c_y[31:0];
                    end
                end
            end
            ST_MM: begin
                case (mm_reg)
                    3'd1:    t1_reg <= q30_round(prod_reg);
                    3'd2:    t2_reg <= q30_round(prod_reg);
                    3'd3:    xm_reg <= prod_reg[DW-1:0];
                    3'd4:    xm_reg <= xm_reg - prod_reg[DW-1:0];
                    3'd5:    xm_reg <= xm_reg + prod_reg[DW-1:0];
                    3'd6:    ym_reg <= prod_reg[DW-1:0];
                    3'd7:    ym_reg <= ym_reg + prod_reg[DW-1:0];
                    default: ;
                endcase
            end
            ST_YV_GO:  if (v_zero) yaw_reg <= '0;
            ST_YV_RUN: if (c_done) yaw_reg <= c_ang;
            default: ;
        endcase
        if (out_load) begin
            out_data_reg <= {6'd0, yaw_reg, theta_reg, phi_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ design/tilt_compensated_compass_fusion_unit.sv @@
`timescale 1ns / 1ps

// Tilt-compensated compass: each 9-axis word gives fused roll and pitch
// (complementary filter of accelerometer atan2 and gyro-advanced angle,
// weighted by keep_weight in Q0.16) and a tilt-compensated yaw, all in
// 1/128 degree. One result word per input word, in order. The sequencer
// runs one word at a time through a single shared CORDIC (one iteration a
// cycle) and one registered 33x33 multiplier: five CORDIC passes (load,
// iterations, done) plus gyro steps, blends, magnetometer multiplies, pop
// and hand-off. An atan2 of a zero vector skips its pass; a stalled result
// register holds the sequencer in hand-off. A two-word queue in front
// accepts new words, until it is full, while the sequencer is busy and the
// result register waits. keep_weight lives at byte address 0 of the APB
// port; values above 65536 act as 65536.

module tilt_compensated_compass_fusion_unit import tccf_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // sample words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, gyro_x, gyro_y, elapsed_ms
    input  logic [143:0] s_axis_tdata,
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_angle[16:0], pitch_angle[33:17], yaw_angle[49:34], zero pad
    output logic [55:0]  m_axis_tdata,
    // APB config
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [16:0] keep_weight_reg;
    logic [16:0] keep_eff;
    logic        q_valid, q_pop;
    sample_t     q_sample;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_weight_reg <= KEEP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_KEEP_WEIGHT)) begin
            keep_weight_reg <= pwdata[16:0];
        end
    end

    assign prdata   = (paddr[2] == REG_KEEP_WEIGHT) ? {15'd0, keep_weight_reg} : '0;
    // weight saturates at one
    assign keep_eff = (keep_weight_reg > KEEP_ONE) ? KEEP_ONE : keep_weight_reg;

    tccf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_sample (sample_t'(s_axis_tdata)),
        .q_valid  (q_valid),
        .q_sample (q_sample),
        .q_pop    (q_pop)
    );

    tccf_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_sample (q_sample),
        .q_pop    (q_pop),
        .keep_eff (keep_eff),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule

@@ design/tccf_checker.sv @@
`timescale 1ns / 1ps

module tccf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        pready
);

    logic signed [16:0] roll_a, pitch_a;
    logic signed [15:0] yaw_a;

    assign roll_a  = m_axis_tdata[16:0];
    assign pitch_a = m_axis_tdata[33:17];
    assign yaw_a   = m_axis_tdata[49:34];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_tilt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (roll_a <= 17'sd46080) && (roll_a >= -17'sd46080)
                       && (pitch_a <= 17'sd46080) && (pitch_a >= -17'sd46080))
        else $error("roll or pitch beyond saturation");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (yaw_a <= 16'sd23040) && (yaw_a >= -16'sd23040)
                       && (m_axis_tdata[55:50] == 6'd0))
        else $error("yaw beyond atan2 range or pad bits set");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready dropped");

endmodule

bind tilt_compensated_compass_fusion_unit tccf_checker u_tccf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
